### rtl/prrs_pkg.sv
// ---------------------------------------------------------------------------
// Scheduler package
// Shared constants, types and helper functions for the priority round-robin
// task scheduler.
// ---------------------------------------------------------------------------
package prrs_pkg;

    localparam int NUM_TASKS = 16;
    localparam int NUM_PRIO  = 8;
    localparam int TASK_W    = $clog2(NUM_TASKS);
    localparam int LINK_W    = TASK_W + 1;
    localparam int PRIO_W    = 3;
    localparam int FNP_W     = 4;
    localparam int DELAY_W   = 32;
    localparam int MASK_W    = 16;

    localparam logic [LINK_W-1:0] NO_TASK   = '1;
    localparam logic [TASK_W-1:0] TASK_LAST = TASK_W'(NUM_TASKS - 1);
    localparam logic [PRIO_W-1:0] PRIO_LAST = PRIO_W'(NUM_PRIO - 1);

    // Operation codes.
    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_SLEEP  = 3'd2;
    localparam logic [2:0] OP_WAKE   = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;
    localparam logic [2:0] OP_SELECT = 3'd5;

    // One entry of the task table memory.
    typedef struct packed {
        logic [LINK_W-1:0]  link;
        logic [PRIO_W-1:0]  prio;
        logic               waiting;
        logic               prim;
        logic [DELAY_W-1:0] delay;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam entry_t ENTRY_RESET = '{
        link: NO_TASK, prio: '0, waiting: 1'b0, prim: 1'b0, delay: '0
    };

    // One request as seen by the controller.
    typedef struct packed {
        logic [2:0]         operation;
        logic [TASK_W-1:0]  task_id;
        logic [PRIO_W-1:0]  prio;
        logic [DELAY_W-1:0] sleep_ticks;
        logic               on_wait_list;
    } req_t;

    // One result as produced by the controller.
    typedef struct packed {
        logic               selected_valid;
        logic [TASK_W-1:0]  selected_task;
        logic [MASK_W-1:0]  timed_out_mask;
        logic [31:0]        tick_total;
        logic [FNP_W-1:0]   first_nonempty;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_WR,
        ST_RD_T,
        ST_SW_WR,
        ST_RM_GET,
        ST_RM_WALK_RD,
        ST_RM_WALK_CHK,
        ST_RM_WR_T,
        ST_TK_RD,
        ST_TK_WR,
        ST_SEL_PRIO,
        ST_SEL_RD,
        ST_SEL_CHK,
        ST_DONE
    } state_t;

    // A link names a real task when it lies inside the table.
    function automatic logic real_task(input logic [LINK_W-1:0] l);
        real_task = (l < LINK_W'(NUM_TASKS));
    endfunction

    // Lowest priority whose list is non-empty, NUM_PRIO when none.
    function automatic logic [FNP_W-1:0] first_set(input logic [NUM_PRIO-1:0] m);
        logic [FNP_W-1:0] r;
        r = FNP_W'(NUM_PRIO);
        for (int p = NUM_PRIO - 1; p >= 0; p--) begin
            if (m[p]) begin
                r = FNP_W'(p);
            end
        end
        first_set = r;
    endfunction

endpackage

### rtl/priority_round_robin_task_scheduler_top.sv
// ---------------------------------------------------------------------------
// Priority round-robin task scheduler
// Unpacks requests, runs the scheduler controller over the task table RAM
// and holds each result in an output register.
// ---------------------------------------------------------------------------
// Per request: remove may walk the list entry by entry, tick visits every task
// slot, and select checks the priorities in turn and tests the entries of each.
// Throughput: one request at a time; the next request is taken the cycle
// after the result moves into the output register.
// Reset empties every list and clears the counters at once; no clearing pass.
module priority_round_robin_task_scheduler_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // task_id[3:0], task_priority_in[6:4], sleep_ticks[38:7], on_wait_list[39]
    input  logic [39:0] s_tdata,
    // operation[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // selected_task[3:0], timed_out_mask[19:4], tick_total[51:20],
    // first_nonempty_priority[55:52]
    output logic [55:0] m_tdata,
    // selected_valid[0]
    output logic [0:0]  m_tuser
);

    prrs_pkg::req_t     req;
    prrs_pkg::result_t  res;
    logic               res_valid;
    logic               res_ready;
    logic               ram_we;
    logic               ram_re;
    logic [prrs_pkg::TASK_W-1:0]  ram_waddr;
    logic [prrs_pkg::TASK_W-1:0]  ram_raddr;
    logic [prrs_pkg::ENTRY_W-1:0] ram_wdata;
    logic [prrs_pkg::ENTRY_W-1:0] ram_rdata;
    logic               m_tvalid_reg;
    logic [55:0]        m_tdata_reg;
    logic [0:0]         m_tuser_reg;

    // Request fields.
    assign req.operation    = s_tuser;
    assign req.task_id      = s_tdata[3:0];
    assign req.prio         = s_tdata[6:4];
    assign req.sleep_ticks  = s_tdata[38:7];
    assign req.on_wait_list = s_tdata[39];

    prrs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    prrs_task_ram #(
        .DEPTH (prrs_pkg::NUM_TASKS),
        .WIDTH (prrs_pkg::ENTRY_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The output register takes a result whenever it is empty or draining.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_tdata_reg <= {res.first_nonempty, res.tick_total,
                            res.timed_out_mask, res.selected_task};
            m_tuser_reg <= res.selected_valid;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/prrs_task_ram.sv
// ---------------------------------------------------------------------------
// Task table RAM
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ---------------------------------------------------------------------------
module prrs_task_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 42
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/prrs_ctrl.sv
// ---------------------------------------------------------------------------
// Scheduler controller
// Sequencer that carries out each request by reading, modifying and writing
// back entries of the task table, and keeps the per-priority list heads,
// cursors and counters.
// ---------------------------------------------------------------------------
module prrs_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  prrs_pkg::req_t                req,
    output logic                          res_valid,
    input  logic                          res_ready,
    output prrs_pkg::result_t             res,
    output logic                          ram_we,
    output logic [prrs_pkg::TASK_W-1:0]   ram_waddr,
    output logic [prrs_pkg::ENTRY_W-1:0]  ram_wdata,
    output logic                          ram_re,
    output logic [prrs_pkg::TASK_W-1:0]   ram_raddr,
    input  logic [prrs_pkg::ENTRY_W-1:0]  ram_rdata
);

    prrs_pkg::state_t state_reg, state_next;

    logic [2:0]                    op_reg, op_next;
    logic [prrs_pkg::TASK_W-1:0]   tid_reg, tid_next;
    logic [prrs_pkg::PRIO_W-1:0]   pin_reg, pin_next;
    logic [prrs_pkg::DELAY_W-1:0]  ticks_reg, ticks_next;
    logic                          prim_reg, prim_next;
    logic [prrs_pkg::TASK_W-1:0]   cur_reg, cur_next;
    logic [prrs_pkg::PRIO_W-1:0]   pr_reg, pr_next;
    logic [prrs_pkg::LINK_W-1:0]   link_t_reg, link_t_next;
    prrs_pkg::entry_t              ent_t_reg, ent_t_next;
    logic [prrs_pkg::TASK_W-1:0]   step_reg, step_next;
    logic [prrs_pkg::MASK_W-1:0]   expired_reg, expired_next;
    logic                          sel_valid_reg, sel_valid_next;
    logic [prrs_pkg::TASK_W-1:0]   sel_task_reg, sel_task_next;
    logic [prrs_pkg::LINK_W-1:0]   head_reg [prrs_pkg::NUM_PRIO];
    logic [prrs_pkg::LINK_W-1:0]   head_next [prrs_pkg::NUM_PRIO];
    logic [prrs_pkg::LINK_W-1:0]   cursor_reg [prrs_pkg::NUM_PRIO];
    logic [prrs_pkg::LINK_W-1:0]   cursor_next [prrs_pkg::NUM_PRIO];
    logic [prrs_pkg::NUM_TASKS-1:0] in_list_reg, in_list_next;
    logic [prrs_pkg::NUM_TASKS-1:0] ent_valid_reg, ent_valid_next;
    logic [prrs_pkg::NUM_PRIO-1:0] mask_reg, mask_next;
    logic [31:0]                   tick_reg, tick_next;
    logic                          rd_valid_reg;

    prrs_pkg::entry_t              rd_ent;
    prrs_pkg::entry_t              wr_ent;
    logic [prrs_pkg::PRIO_W-1:0]   ent_pr;
    logic [prrs_pkg::TASK_W-1:0]   sel_nxt;
    logic                          prio_ok;
    logic [prrs_pkg::DELAY_W-1:0]  delay_dec;

    // An entry never written reads as its reset value.
    assign rd_ent    = rd_valid_reg ? prrs_pkg::entry_t'(ram_rdata) : prrs_pkg::ENTRY_RESET;
    assign ent_pr    = rd_ent.prio;
    assign sel_nxt   = prrs_pkg::real_task(rd_ent.link) ? rd_ent.link[prrs_pkg::TASK_W-1:0]
                                                        : head_reg[pr_reg][prrs_pkg::TASK_W-1:0];
    assign prio_ok   = (int'(req.prio) < prrs_pkg::NUM_PRIO);
    assign delay_dec = rd_ent.delay - prrs_pkg::DELAY_W'(1);
    assign ram_wdata = wr_ent;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            prrs_pkg::ST_IDLE: begin
                if (in_valid) begin
                    case (req.operation)
                        prrs_pkg::OP_ADD: begin
                            state_next = (in_list_reg[req.task_id] || !prio_ok)
                                       ? prrs_pkg::ST_DONE : prrs_pkg::ST_ADD_WR;
                        end
                        prrs_pkg::OP_REMOVE: begin
                            state_next = in_list_reg[req.task_id]
                                       ? prrs_pkg::ST_RD_T : prrs_pkg::ST_DONE;
                        end
                        prrs_pkg::OP_SLEEP:  state_next = prrs_pkg::ST_RD_T;
                        prrs_pkg::OP_WAKE:   state_next = prrs_pkg::ST_RD_T;
                        prrs_pkg::OP_TICK:   state_next = prrs_pkg::ST_TK_RD;
                        prrs_pkg::OP_SELECT: state_next = prrs_pkg::ST_SEL_PRIO;
                        default:             state_next = prrs_pkg::ST_DONE;
                    endcase
                end
            end
            prrs_pkg::ST_ADD_WR: state_next = prrs_pkg::ST_DONE;
            prrs_pkg::ST_RD_T: begin
                state_next = (op_reg == prrs_pkg::OP_REMOVE) ? prrs_pkg::ST_RM_GET
                                                             : prrs_pkg::ST_SW_WR;
            end
            prrs_pkg::ST_SW_WR: state_next = prrs_pkg::ST_DONE;
            prrs_pkg::ST_RM_GET: begin
                if (head_reg[ent_pr] == prrs_pkg::LINK_W'(tid_reg)
                    || !prrs_pkg::real_task(head_reg[ent_pr])) begin
                    state_next = prrs_pkg::ST_RM_WR_T;
                end else begin
                    state_next = prrs_pkg::ST_RM_WALK_RD;
                end
            end
            prrs_pkg::ST_RM_WALK_RD: state_next = prrs_pkg::ST_RM_WALK_CHK;
            prrs_pkg::ST_RM_WALK_CHK: begin
                if (rd_ent.link == prrs_pkg::LINK_W'(tid_reg)) begin
                    state_next = prrs_pkg::ST_RM_WR_T;
                end else if (prrs_pkg::real_task(rd_ent.link)
                             && step_reg != prrs_pkg::TASK_LAST) begin
                    state_next = prrs_pkg::ST_RM_WALK_RD;
                end else begin
                    state_next = prrs_pkg::ST_RM_WR_T;
                end
            end
            prrs_pkg::ST_RM_WR_T: state_next = prrs_pkg::ST_DONE;
            prrs_pkg::ST_TK_RD:   state_next = prrs_pkg::ST_TK_WR;
            prrs_pkg::ST_TK_WR: begin
                state_next = (cur_reg == prrs_pkg::TASK_LAST) ? prrs_pkg::ST_DONE
                                                              : prrs_pkg::ST_TK_RD;
            end
            prrs_pkg::ST_SEL_PRIO: begin
                if (prrs_pkg::real_task(head_reg[pr_reg])) begin
                    state_next = prrs_pkg::ST_SEL_RD;
                end else if (pr_reg == prrs_pkg::PRIO_LAST) begin
                    state_next = prrs_pkg::ST_DONE;
                end
            end
            prrs_pkg::ST_SEL_RD: state_next = prrs_pkg::ST_SEL_CHK;
            prrs_pkg::ST_SEL_CHK: begin
                if (!rd_ent.waiting) begin
                    state_next = prrs_pkg::ST_DONE;
                end else if (step_reg == prrs_pkg::TASK_LAST) begin
                    state_next = (pr_reg == prrs_pkg::PRIO_LAST) ? prrs_pkg::ST_DONE
                                                                 : prrs_pkg::ST_SEL_PRIO;
                end else begin
                    state_next = prrs_pkg::ST_SEL_RD;
                end
            end
            prrs_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = prrs_pkg::ST_IDLE;
                end
            end
            default: state_next = prrs_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control for each state.
    always_comb begin
        op_next        = op_reg;
        tid_next       = tid_reg;
        pin_next       = pin_reg;
        ticks_next     = ticks_reg;
        prim_next      = prim_reg;
        cur_next       = cur_reg;
        pr_next        = pr_reg;
        link_t_next    = link_t_reg;
        ent_t_next     = ent_t_reg;
        step_next      = step_reg;
        expired_next   = expired_reg;
        sel_valid_next = sel_valid_reg;
        sel_task_next  = sel_task_reg;
        head_next      = head_reg;
        cursor_next    = cursor_reg;
        in_list_next   = in_list_reg;
        ent_valid_next = ent_valid_reg;
        mask_next      = mask_reg;
        tick_next      = tick_reg;
        ram_we         = 1'b0;
        ram_waddr      = tid_reg;
        wr_ent         = rd_ent;
        ram_re         = 1'b0;
        ram_raddr      = tid_reg;
        in_ready       = (state_reg == prrs_pkg::ST_IDLE);
        res_valid      = (state_reg == prrs_pkg::ST_DONE);

        case (state_reg)
            prrs_pkg::ST_IDLE: begin
                if (in_valid) begin
                    op_next        = req.operation;
                    tid_next       = req.task_id;
                    pin_next       = req.prio;
                    ticks_next     = req.sleep_ticks;
                    prim_next      = req.on_wait_list;
                    sel_valid_next = 1'b0;
                    sel_task_next  = '0;
                    expired_next   = '0;
                    step_next      = '0;
                    cur_next       = '0;
                    pr_next        = '0;
                    if (req.operation == prrs_pkg::OP_TICK) begin
                        tick_next = tick_reg + 32'd1;
                    end
                end
            end
            // Push the new task at the head of its list.
            prrs_pkg::ST_ADD_WR: begin
                ram_we                 = 1'b1;
                wr_ent                 = prrs_pkg::ENTRY_RESET;
                wr_ent.link            = head_reg[pin_reg];
                wr_ent.prio            = pin_reg;
                head_next[pin_reg]     = prrs_pkg::LINK_W'(tid_reg);
                in_list_next[tid_reg]  = 1'b1;
                ent_valid_next[tid_reg] = 1'b1;
                mask_next[pin_reg]     = 1'b1;
            end
            prrs_pkg::ST_RD_T: begin
                ram_re = 1'b1;
            end
            // Sleep or wake rewrites the slot's timing fields.
            prrs_pkg::ST_SW_WR: begin
                ram_we = 1'b1;
                wr_ent = rd_ent;
                if (op_reg == prrs_pkg::OP_SLEEP) begin
                    wr_ent.delay   = ticks_reg;
                    wr_ent.waiting = 1'b1;
                    wr_ent.prim    = prim_reg;
                end else begin
                    wr_ent.waiting = 1'b0;
                end
                ent_valid_next[tid_reg] = 1'b1;
            end
            // The removed task's entry is in; unlink it at the head or walk.
            prrs_pkg::ST_RM_GET: begin
                pr_next     = ent_pr;
                link_t_next = rd_ent.link;
                ent_t_next  = rd_ent;
                cur_next    = head_reg[ent_pr][prrs_pkg::TASK_W-1:0];
                if (cursor_reg[ent_pr] == prrs_pkg::LINK_W'(tid_reg)) begin
                    cursor_next[ent_pr] = prrs_pkg::NO_TASK;
                end
                if (head_reg[ent_pr] == prrs_pkg::LINK_W'(tid_reg)) begin
                    head_next[ent_pr] = rd_ent.link;
                end
            end
            prrs_pkg::ST_RM_WALK_RD: begin
                ram_re    = 1'b1;
                ram_raddr = cur_reg;
            end
            // Point the predecessor past the removed task if found, else step to the next entry.
            prrs_pkg::ST_RM_WALK_CHK: begin
                if (rd_ent.link == prrs_pkg::LINK_W'(tid_reg)) begin
                    ram_we      = 1'b1;
                    ram_waddr   = cur_reg;
                    wr_ent      = rd_ent;
                    wr_ent.link = link_t_reg;
                    ent_valid_next[cur_reg] = 1'b1;
                end else begin
                    cur_next  = rd_ent.link[prrs_pkg::TASK_W-1:0];
                    step_next = step_reg + prrs_pkg::TASK_W'(1);
                end
            end
            prrs_pkg::ST_RM_WR_T: begin
                ram_we                  = 1'b1;
                wr_ent                  = ent_t_reg;
                wr_ent.link             = prrs_pkg::NO_TASK;
                ent_valid_next[tid_reg] = 1'b1;
                in_list_next[tid_reg]   = 1'b0;
                if (!prrs_pkg::real_task(head_reg[pr_reg])) begin
                    mask_next[pr_reg] = 1'b0;
                end
            end
            prrs_pkg::ST_TK_RD: begin
                ram_re    = 1'b1;
                ram_raddr = cur_reg;
            end
            // Count down one listed waiter; expiry makes it ready.
            prrs_pkg::ST_TK_WR: begin
                ram_waddr = cur_reg;
                wr_ent    = rd_ent;
                if (in_list_reg[cur_reg] && rd_ent.waiting && rd_ent.delay != '0) begin
                    ram_we       = 1'b1;
                    wr_ent.delay = delay_dec;
                    if (delay_dec == '0) begin
                        wr_ent.waiting = 1'b0;
                        if (rd_ent.prim) begin
                            wr_ent.prim           = 1'b0;
                            expired_next[cur_reg] = 1'b1;
                        end
                    end
                end
                cur_next = cur_reg + prrs_pkg::TASK_W'(1);
            end
            // Start the circular walk of a non-empty list at its cursor or head; else skip it.
            prrs_pkg::ST_SEL_PRIO: begin
                step_next = '0;
                if (prrs_pkg::real_task(head_reg[pr_reg])) begin
                    cur_next = prrs_pkg::real_task(cursor_reg[pr_reg])
                             ? cursor_reg[pr_reg][prrs_pkg::TASK_W-1:0]
                             : head_reg[pr_reg][prrs_pkg::TASK_W-1:0];
                end else if (pr_reg != prrs_pkg::PRIO_LAST) begin
                    pr_next = pr_reg + prrs_pkg::PRIO_W'(1);
                end
            end
            prrs_pkg::ST_SEL_RD: begin
                ram_re    = 1'b1;
                ram_raddr = cur_reg;
            end
            prrs_pkg::ST_SEL_CHK: begin
                if (!rd_ent.waiting) begin
                    sel_valid_next      = 1'b1;
                    sel_task_next       = cur_reg;
                    cursor_next[pr_reg] = prrs_pkg::LINK_W'(sel_nxt);
                end else if (step_reg == prrs_pkg::TASK_LAST) begin
                    if (pr_reg != prrs_pkg::PRIO_LAST) begin
                        pr_next = pr_reg + prrs_pkg::PRIO_W'(1);
                    end
                end else begin
                    cur_next  = sel_nxt;
                    step_next = step_reg + prrs_pkg::TASK_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign res.selected_valid = sel_valid_reg;
    assign res.selected_task  = sel_task_reg;
    assign res.timed_out_mask = expired_reg;
    assign res.tick_total     = tick_reg;
    assign res.first_nonempty = prrs_pkg::first_set(mask_reg);

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= prrs_pkg::ST_IDLE;
            head_reg      <= '{default: prrs_pkg::NO_TASK};
            cursor_reg    <= '{default: prrs_pkg::NO_TASK};
            in_list_reg   <= '0;
            ent_valid_reg <= '0;
            mask_reg      <= '0;
            tick_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cursor_reg    <= cursor_next;
            in_list_reg   <= in_list_next;
            ent_valid_reg <= ent_valid_next;
            mask_reg      <= mask_next;
            tick_reg      <= tick_next;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        tid_reg       <= tid_next;
        pin_reg       <= pin_next;
        ticks_reg     <= ticks_next;
        prim_reg      <= prim_next;
        cur_reg       <= cur_next;
        pr_reg        <= pr_next;
        link_t_reg    <= link_t_next;
        ent_t_reg     <= ent_t_next;
        step_reg      <= step_next;
        expired_reg   <= expired_next;
        sel_valid_reg <= sel_valid_next;
        sel_task_reg  <= sel_task_next;
        if (ram_re) begin
            rd_valid_reg <= ent_valid_reg[ram_raddr];
        end
    end

`ifndef NO_ASSERTIONS
    // A task in a list always has a written table entry.
    a_list_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_list_reg & ~ent_valid_reg) == '0)
        else $error("listed task without a written entry");

    // The memory is never read and written at the same entry in one cycle.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re && ram_waddr == ram_raddr))
        else $error("read and write collide on one entry");

    // An accepted tick advances the tick counter by one.
    a_tick_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && req.operation == prrs_pkg::OP_TICK)
        |=> tick_reg == $past(tick_reg) + 32'd1)
        else $error("tick counter did not advance");

    // A selected task always comes from a non-empty priority.
    a_sel_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && sel_valid_reg) |-> mask_reg != '0)
        else $error("task selected with all lists empty");
`endif

endmodule
